/* hw/rtl/quaternion_multiply_normalize_core_assert.svh */
// Assertion macros shared by the checker.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_CORE_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_CORE_ASSERT_SVH

// Checked only outside reset.
`define QMN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qmn assertion failed");

// Checked at every edge, reset included.
`define QMN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("qmn assertion failed");

`endif

/* hw/rtl/qmn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qmn_pkg;
  localparam int unsigned DW   = 16;   // field width
  localparam int unsigned PW   = 32;   // 16x16 product
  localparam int unsigned CW   = 34;   // product component
  localparam int unsigned MW   = 33;   // magnitude of a component
  localparam int unsigned SQW  = 66;   // square of a component
  localparam int unsigned SW   = 68;   // sum of four squares
  localparam int unsigned WW   = 100;  // search arithmetic
  localparam int unsigned NS   = 15;   // search steps, one result bit each
  localparam int unsigned RSH  = 30;   // (2 * one)^2 as a shift
  localparam int unsigned NLANE = 4;

  typedef logic signed [DW-1:0] field_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic [NS-1:0]        res_t;
endpackage
`default_nettype wire

/* hw/rtl/qmn_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface qmn_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] p_w;
  logic signed [15:0] p_x;
  logic signed [15:0] p_y;
  logic signed [15:0] p_z;
  logic signed [15:0] q_w;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;
  modport source (output valid, p_w, p_x, p_y, p_z, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, p_w, p_x, p_y, p_z, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qmn_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] r_w;
  logic signed [15:0] r_x;
  logic signed [15:0] r_y;
  logic signed [15:0] r_z;
  modport source (output valid, r_w, r_x, r_y, r_z, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, output ready);
endinterface
`default_nettype wire

/* hw/rtl/quaternion_multiply_normalize_core.sv */
// Pipeline: 20 register stages: 4 product and magnitude stages, 15 search stages resolving
// one result bit each, 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while a result is refused.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_multiply_normalize_core (
  input  wire logic clk,
  input  wire logic rst_n,
  qmn_in_if.sink    in_ch,
  qmn_out_if.source out_ch
);
  import qmn_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r, out_v_r;
  logic [NS:0] vs_r;

  logic signed [PW-1:0] prod_r [0:15];
  logic signed [CW-1:0] c_r [0:NLANE-1];
  logic [SQW-1:0]       sq_r [0:NLANE-1];
  logic                 neg3_r [0:NLANE-1];

  wide_t a_r   [0:NS][0:NLANE-1];
  wide_t b_r   [0:NS][0:NLANE-1];
  wide_t rhs_r [0:NS][0:NLANE-1];
  res_t  n_r   [0:NS][0:NLANE-1];
  logic  neg_r [0:NS][0:NLANE-1];
  wide_t s_r   [0:NS];
  logic  zero_r [0:NS];

  field_t r_r [0:NLANE-1];

  wide_t s_sum;
  wide_t cand [0:NS-1][0:NLANE-1];
  logic  take [0:NS-1][0:NLANE-1];
  logic signed [CW-1:0] c_nxt [0:NLANE-1];

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = out_v_r;
  assign out_ch.r_w  = r_r[0];
  assign out_ch.r_x  = r_r[1];
  assign out_ch.r_y  = r_r[2];
  assign out_ch.r_z  = r_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      vs_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vs_r    <= {vs_r[NS-1:0], v3_r};
      out_v_r <= vs_r[NS];
    end
  end

  always_comb begin
    c_nxt[0] = CW'(prod_r[0]) - CW'(prod_r[1]) - CW'(prod_r[2]) - CW'(prod_r[3]);
    c_nxt[1] = CW'(prod_r[4]) + CW'(prod_r[5]) + CW'(prod_r[6]) - CW'(prod_r[7]);
    c_nxt[2] = CW'(prod_r[8]) + CW'(prod_r[9]) + CW'(prod_r[10]) - CW'(prod_r[11]);
    c_nxt[3] = CW'(prod_r[12]) + CW'(prod_r[13]) + CW'(prod_r[14]) - CW'(prod_r[15]);
    s_sum = WW'(sq_r[0]) + WW'(sq_r[1]) + WW'(sq_r[2]) + WW'(sq_r[3]);
  end

  // Greedy bit search for the largest n with s*(2n-1)^2 <= (2*one)^2*c^2.
  // With a = s*(2n-1)^2 and b = s*(2n-1), trying bit k adds
  // b*2^(k+2) + s*2^(2k+2) to a, so each step is shifts and adds.
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      for (int l = 0; l < NLANE; l++) begin
        cand[j][l] = a_r[j][l] + (b_r[j][l] <<< (NS - 1 - j + 2))
                     + (s_r[j] <<< (2 * (NS - 1 - j) + 2));
        take[j][l] = cand[j][l] <= rhs_r[j][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [MW-1:0] mag;
    if (en) begin
      prod_r[0]  <= in_ch.p_w * in_ch.q_w;
      prod_r[1]  <= in_ch.p_x * in_ch.q_x;
      prod_r[2]  <= in_ch.p_y * in_ch.q_y;
      prod_r[3]  <= in_ch.p_z * in_ch.q_z;
      prod_r[4]  <= in_ch.p_w * in_ch.q_x;
      prod_r[5]  <= in_ch.p_x * in_ch.q_w;
      prod_r[6]  <= in_ch.p_y * in_ch.q_z;
      prod_r[7]  <= in_ch.p_z * in_ch.q_y;
      prod_r[8]  <= in_ch.p_w * in_ch.q_y;
      prod_r[9]  <= in_ch.p_y * in_ch.q_w;
      prod_r[10] <= in_ch.p_z * in_ch.q_x;
      prod_r[11] <= in_ch.p_x * in_ch.q_z;
      prod_r[12] <= in_ch.p_w * in_ch.q_z;
      prod_r[13] <= in_ch.p_z * in_ch.q_w;
      prod_r[14] <= in_ch.p_x * in_ch.q_y;
      prod_r[15] <= in_ch.p_y * in_ch.q_x;
      for (int l = 0; l < NLANE; l++) begin
        c_r[l] <= c_nxt[l];
        mag = c_r[l][CW-1] ? MW'(-c_r[l]) : MW'(c_r[l]);
        sq_r[l]   <= SQW'(mag) * SQW'(mag);
        neg3_r[l] <= c_r[l][CW-1];
        a_r[0][l]   <= s_sum;
        b_r[0][l]   <= -s_sum;
        rhs_r[0][l] <= WW'(sq_r[l]) << RSH;
        n_r[0][l]   <= '0;
        neg_r[0][l] <= neg3_r[l];
      end
      s_r[0]    <= s_sum;
      zero_r[0] <= (s_sum == '0);
      for (int j = 0; j < NS; j++) begin
        for (int l = 0; l < NLANE; l++) begin
          a_r[j+1][l]   <= take[j][l] ? cand[j][l] : a_r[j][l];
          b_r[j+1][l]   <= take[j][l] ? b_r[j][l] + (s_r[j] <<< (NS - 1 - j + 1))
                                      : b_r[j][l];
          n_r[j+1][l]   <= n_r[j][l] | (take[j][l] ? NS'(1) << (NS - 1 - j) : '0);
          rhs_r[j+1][l] <= rhs_r[j][l];
          neg_r[j+1][l] <= neg_r[j][l];
        end
        s_r[j+1]    <= s_r[j];
        zero_r[j+1] <= zero_r[j];
      end
      for (int l = 0; l < NLANE; l++) begin
        if (zero_r[NS]) begin
          r_r[l] <= '0;
        end else if (neg_r[NS][l]) begin
          r_r[l] <= -DW'(n_r[NS][l]);
        end else begin
          r_r[l] <= DW'(n_r[NS][l]);
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/qmn_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_multiply_normalize_core_assert.svh"
module qmn_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic signed [15:0] r_w,
  input wire logic signed [15:0] r_x,
  input wire logic signed [15:0] r_y,
  input wire logic signed [15:0] r_z
);
  // Results are unit quaternion components, never beyond plus or minus one.
  `QMN_ASSERT(a_range, out_valid |-> (r_w <= 16384 && r_w >= -16384 && r_x <= 16384 && r_x >= -16384 && r_y <= 16384 && r_y >= -16384 && r_z <= 16384 && r_z >= -16384))
  `QMN_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable({r_w, r_x, r_y, r_z}))
  // An empty output register never blocks the input.
  `QMN_ASSERT(a_ready, !out_valid |-> in_ready)
  `QMN_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid)
endmodule

bind quaternion_multiply_normalize_core qmn_checker u_qmn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .r_w       (out_ch.r_w),
  .r_x       (out_ch.r_x),
  .r_y       (out_ch.r_y),
  .r_z       (out_ch.r_z)
);
`default_nettype wire

/* verif/quaternion_multiply_normalize_core_tb.sv */
`timescale 1ns / 1ps
module quaternion_multiply_normalize_core_tb;
  import qmn_pkg::*;

  localparam int NUM_RANDOM   = 1330;
  localparam int QUIET_FROM   = 1200;  // no idling on either side after this item
  localparam int HOLD_AT      = 400;   // long receiver hold-off starts here
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ONE          = 16384;

  typedef struct packed {
    field_t pw, px, py, pz, qw, qx, qy, qz;
  } qpair_t;

  typedef struct packed {
    field_t w, x, y, z;
  } unit_quat_t;

  typedef struct packed {
    qpair_t     operands;
    logic       known;    // expected result typed in by hand
    unit_quat_t product;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  qmn_in_if  in_ch();
  qmn_out_if out_ch();

  quaternion_multiply_normalize_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  unit_quat_t expected_products[$];
  int         mismatches = 0;
  int         items_sent = 0;
  bit         quiet = 1'b0;
  longint     cycle_count = 0;

  // Exact normalisation: largest n with s*(2n-1)^2 <= (2*ONE)^2 * c^2, found by bisection.
  function automatic unit_quat_t normalised_product(qpair_t a);
    longint       comp [4];
    logic [127:0] sum_sq, mag, rhs, odd;
    int           lo, hi, mid;
    field_t       res [4];
    unit_quat_t   r;
    comp[0] = longint'(a.pw) * a.qw - longint'(a.px) * a.qx
            - longint'(a.py) * a.qy - longint'(a.pz) * a.qz;
    comp[1] = longint'(a.pw) * a.qx + longint'(a.px) * a.qw
            + longint'(a.py) * a.qz - longint'(a.pz) * a.qy;
    comp[2] = longint'(a.pw) * a.qy + longint'(a.py) * a.qw
            + longint'(a.pz) * a.qx - longint'(a.px) * a.qz;
    comp[3] = longint'(a.pw) * a.qz + longint'(a.pz) * a.qw
            + longint'(a.px) * a.qy - longint'(a.py) * a.qx;
    sum_sq = '0;
    for (int i = 0; i < 4; i++) begin
      mag = comp[i] < 0 ? 128'(-comp[i]) : 128'(comp[i]);
      sum_sq += mag * mag;
    end
    for (int i = 0; i < 4; i++) begin
      lo = 0;
      if (sum_sq != 0) begin
        mag = comp[i] < 0 ? 128'(-comp[i]) : 128'(comp[i]);
        rhs = (mag * mag) << 30;
        hi = ONE;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          odd = 128'(2 * mid - 1);
          if (sum_sq * odd * odd <= rhs) lo = mid;
          else hi = mid - 1;
        end
      end
      res[i] = field_t'(comp[i] < 0 ? -lo : lo);
    end
    r.w = res[0]; r.x = res[1]; r.y = res[2]; r.z = res[3];
    return r;
  endfunction

  function automatic field_t any_field();
    return field_t'($urandom_range(65535, 0));
  endfunction

  function automatic field_t small_field();
    return field_t'(int'($urandom_range(6, 0)) - 3);
  endfunction

  function automatic qpair_t random_pair();
    qpair_t a;
    int     kind;
    kind = $urandom_range(9, 0);
    a = {any_field(), any_field(), any_field(), any_field(),
         any_field(), any_field(), any_field(), any_field()};
    if (kind < 2) begin
      // Small values: products are short and rounding ties are likelier.
      a.pw = small_field(); a.px = small_field();
      a.py = small_field(); a.pz = small_field();
      a.qw = small_field(); a.qx = small_field();
      a.qy = small_field(); a.qz = small_field();
    end else if (kind == 2) begin
      // One operand all zero gives a zero product.
      if ($urandom_range(1, 0)) {a.pw, a.px, a.py, a.pz} = '0;
      else {a.qw, a.qx, a.qy, a.qz} = '0;
    end else if (kind == 3) begin
      // w near one and x small on both sides, as in near-unit rotations; y and z stay random.
      a.pw = field_t'($urandom_range(ONE + 200, ONE - 200));
      a.qw = field_t'($urandom_range(ONE + 200, ONE - 200));
      a.px = field_t'(int'($urandom_range(400, 0)) - 200);
      a.qx = field_t'(int'($urandom_range(400, 0)) - 200);
    end else if (kind == 4) begin
      // Only w is kept on each side; x, y and z are zero.
      {a.px, a.py, a.pz, a.qx, a.qy, a.qz} = '0;
    end
    return a;
  endfunction

  directed_row_t directed [] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
    '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0},
      1'b1, '{16'sd0, 16'sd16384, 16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0},
      1'b1, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0},
      1'b1, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1},
      1'b1, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
    '{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
    '{'{16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
        -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
        16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
    '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
        -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd1, 16'sd2, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0},
      1'b0, '0},
    '{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1}, 1'b0, '0},
    '{'{16'sd3, -16'sd7, 16'sd12, -16'sd1, 16'sd9, 16'sd4, -16'sd6, 16'sd2}, 1'b0, '0}
  };

  // Offers one item, waits for acceptance, records the expected result, then may drop valid at random.
  task automatic offer_item(qpair_t a, unit_quat_t want);
    in_ch.valid <= 1'b1;
    in_ch.p_w <= a.pw; in_ch.p_x <= a.px; in_ch.p_y <= a.py; in_ch.p_z <= a.pz;
    in_ch.q_w <= a.qw; in_ch.q_x <= a.qx; in_ch.q_y <= a.qy; in_ch.q_z <= a.qz;
    do @(posedge clk); while (!in_ch.ready);
    expected_products.push_back(want);
    items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
    if (!quiet && $urandom_range(3, 0) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  initial begin
    qpair_t a;
    in_ch.valid = 1'b0;
    {in_ch.p_w, in_ch.p_x, in_ch.p_y, in_ch.p_z} = '0;
    {in_ch.q_w, in_ch.q_x, in_ch.q_y, in_ch.q_z} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      offer_item(directed[i].operands, directed[i].known ? directed[i].product
                                                           : normalised_product(directed[i].operands));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      a = random_pair();
      offer_item(a, normalised_product(a));
    end
    in_ch.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("quaternion_multiply_normalize_core_tb: done, clean");
    else $display("quaternion_multiply_normalize_core_tb: done, errors");
    $finish;
  end

  // Receiver: short random refusals, plus one long hold-off that fills the pipeline.
  int  refuse_left = 0;
  bit  held = 1'b0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!held && items_sent >= HOLD_AT) begin
      held <= 1'b1;
      refuse_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (refuse_left > 0) begin
      refuse_left <= refuse_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(4, 0) == 0) begin
      refuse_left <= $urandom_range(3, 0);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    unit_quat_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.r_w, out_ch.r_x, out_ch.r_y, out_ch.r_z};
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: w=%0d x=%0d y=%0d z=%0d",
                   got.w, got.x, got.y, got.z);
      end else begin
        want = expected_products.pop_front();
        if (got.w !== want.w || got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quaternion_multiply_normalize_core_tb: done, errors");
      $finish;
    end
  end
endmodule
